// ===== rtl/evg_pkg.sv =====
`default_nettype none

package evg_pkg;

    // Default parameter values.
    localparam int MAX_POINTS_DEF       = 64;
    localparam int PHASE_BITS_DEF       = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Field widths of a request and of a vertex.
    localparam int CENTER_W = 16;
    localparam int RADIUS_W = 15;
    localparam int COUNT_W  = 7;
    localparam int VERTEX_W = 17;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_top;
        logic issue;
        logic last;
    } evg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;
        logic empty;
    } evg_status_t;

endpackage

`default_nettype wire

// ===== rtl/ellipse_vertex_generator.sv =====
// After a request is accepted the serial divider runs; each issued vertex then
// passes the table index, table read, quadrant fold and centre add stages.
// Throughput: one vertex a cycle while the output is taken; a new request is
// taken only after the serial divider has run and the pipeline has drained.
// Reset: rst_n clears the controller and pipeline valid bits asynchronously.
`default_nettype none

module ellipse_vertex_generator #(
    parameter int MAX_POINTS       = evg_pkg::MAX_POINTS_DEF,
    parameter int PHASE_BITS       = evg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = evg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // center_x[15:0], center_y[31:16], radius_x[46:32], radius_y[61:47],
    // point_count[68:62], zero fill above
    input  wire logic [evg_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // vertex_x[16:0], vertex_y[33:17], zero fill above
    output logic [evg_pkg::OUT_W-1:0]        m_axis_tdata,
    output logic                             m_axis_tlast
);
    import evg_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);

    evg_cmd_t                    cmd;
    evg_status_t                 status;
    logic                        idle;
    logic [NW-1:0]               divisor;
    logic signed [VERTEX_W-1:0]  vertex_x, vertex_y;

    assign s_axis_tready = idle;

    evg_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .PHASE_BITS (PHASE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_axis_tvalid),
        .point_count (s_axis_tdata[68:62]),
        .status      (status),
        .idle        (idle),
        .divisor     (divisor),
        .cmd         (cmd)
    );

    evg_datapath #(
        .MAX_POINTS       (MAX_POINTS),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .divisor     (divisor),
        .center_x    (s_axis_tdata[15:0]),
        .center_y    (s_axis_tdata[31:16]),
        .radius_x    (s_axis_tdata[46:32]),
        .radius_y    (s_axis_tdata[61:47]),
        .out_ready   (m_axis_tready),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_W - 2 * VERTEX_W)'(0), vertex_y, vertex_x};

    // A new request is only taken once every vertex has left.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request accepted with vertices still pending");

    // The final vertex leaves nothing behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("vertex emitted after the final one");

    // The block is busy right after taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after request transaction");

endmodule

`default_nettype wire

// ===== rtl/evg_ctrl.sv =====
`default_nettype none

module evg_ctrl #(
    parameter int MAX_POINTS = evg_pkg::MAX_POINTS_DEF,
    parameter int PHASE_BITS = evg_pkg::PHASE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [evg_pkg::COUNT_W-1:0]   point_count,
    input  wire evg_pkg::evg_status_t          status,
    output logic                               idle,
    output logic [$clog2(MAX_POINTS+1)-1:0]    divisor,
    output evg_pkg::evg_cmd_t                  cmd
);
    import evg_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(PHASE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t          state_reg, state_next;
    logic [NW-1:0]   count_reg, count_next;
    logic [NW-1:0]   index_reg, index_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [NW-1:0]   clamped;

    // Clamp the vertex count to the supported range.
    always_comb
    begin
        if (int'(point_count) < 3)
            clamped = NW'(3);
        else if (int'(point_count) > MAX_POINTS)
            clamped = NW'(MAX_POINTS);
        else
            clamped = NW'(point_count);
    end

    assign idle    = (state_reg == ST_IDLE);
    assign divisor = count_reg - NW'(2);

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        index_next = index_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    count_next = clamped;
                    index_next = '0;
                    step_next  = CW'(PHASE_BITS);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.div_top  = (step_reg == CW'(PHASE_BITS));
                step_next    = step_reg - CW'(1);
                if (step_reg == '0)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (status.advance)
                begin
                    cmd.issue  = 1'b1;
                    cmd.last   = (index_reg == count_reg - NW'(1));
                    index_next = index_reg + NW'(1);
                    if (cmd.last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.empty)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= NW'(3);
            index_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            index_reg <= index_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/evg_datapath.sv =====
`default_nettype none

module evg_datapath #(
    parameter int MAX_POINTS       = evg_pkg::MAX_POINTS_DEF,
    parameter int PHASE_BITS       = evg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = evg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire evg_pkg::evg_cmd_t                   cmd,
    input  wire logic [$clog2(MAX_POINTS+1)-1:0]     divisor,
    input  wire logic signed [evg_pkg::CENTER_W-1:0] center_x,
    input  wire logic signed [evg_pkg::CENTER_W-1:0] center_y,
    input  wire logic [evg_pkg::RADIUS_W-1:0]        radius_x,
    input  wire logic [evg_pkg::RADIUS_W-1:0]        radius_y,
    input  wire logic                                out_ready,
    output evg_pkg::evg_status_t                     status,
    output logic                                     out_valid,
    output logic signed [evg_pkg::VERTEX_W-1:0]      vertex_x,
    output logic signed [evg_pkg::VERTEX_W-1:0]      vertex_y,
    output logic                                     last_vertex
);
    import evg_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int PB = PHASE_BITS;
    localparam int FW = PHASE_BITS - 2;
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = AW + 1;
    localparam int TW = 17;
    localparam int SW = 18;
    localparam int PW = 34;
    localparam int VW = 35;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    localparam logic [TW-1:0] TrigOne = TW'(65536);
    localparam logic [DW-1:0] DepthC  = DW'(SINE_TABLE_DEPTH);

    typedef logic [TW-1:0] rom_t [SINE_TABLE_DEPTH];

    // Unsigned division by shift and subtract, used only to build the table.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        begin
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            udiv64 = quo;
        end
    endfunction

    // Quarter-wave sine in Q16 from a truncating Taylor series in Q2.30.
    function automatic logic [TW-1:0] taylor_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        begin
            x    = udiv64(64'd1686629713 * 64'(k), 64'(SINE_TABLE_DEPTH));
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                term = (term * x2) >> 30;
                term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            taylor_sine = TW'((sum + 8192) >>> 14);
        end
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        begin
            for (int k = 0; k < SINE_TABLE_DEPTH; k++)
                r[k] = taylor_sine(k);
            build_rom = r;
        end
    endfunction

    localparam rom_t SineRom = build_rom();

    // Latched request.
    logic signed [CENTER_W-1:0] cx_reg, cy_reg;
    logic [RADIUS_W-1:0]        rx_reg, ry_reg;
    logic [NW-1:0]              div_reg;

    // Divider and phase accumulator.
    logic [NW:0]    rem_reg;
    logic [PB-1:0]  quo_reg;
    logic [PB-1:0]  phase_reg;
    logic [NW:0]    rem_shift;
    logic           quo_bit;

    // Pipeline stages.
    logic               advance;
    logic               v1_reg, v2_reg, v3_reg, vo_reg;
    logic               l1_reg, l2_reg, l3_reg, lo_reg;
    logic [1:0]         q1_reg, q2_reg;
    logic [AW-1:0]      p1_reg;
    logic [DW-1:0]      pc1_reg;
    logic [TW-1:0]      sp2_reg, sc2_reg;
    logic signed [PW-1:0] px3_reg, py3_reg;
    logic signed [VERTEX_W-1:0] vx_reg, vy_reg;

    logic [FW+DW-1:0]   p_full;
    logic [AW-1:0]      p_idx;
    logic signed [SW-1:0] sp_s, sc_s, sin_s, cos_s;
    logic signed [VW-1:0] sum_x, sum_y;

    assign advance        = !vo_reg || out_ready;
    assign status.advance = advance;
    assign status.empty   = !v1_reg && !v2_reg && !v3_reg && !vo_reg;

    // Latch the request on load, and the divisor on the first divide step.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            rx_reg  <= radius_x;
            ry_reg  <= radius_y;
        end
        if (cmd.div_step && cmd.div_top)
            div_reg <= divisor;
    end

    // Restoring division of 2^PHASE_BITS by the divisor, one bit a cycle.
    always_comb
    begin
        rem_shift = {rem_reg[NW-1:0], cmd.div_top};
        quo_bit   = (rem_shift >= {1'b0, (cmd.div_top ? divisor : div_reg)});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                rem_reg <= quo_bit
                    ? rem_shift - {1'b0, (cmd.div_top ? divisor : div_reg)}
                    : rem_shift;
                quo_reg <= {quo_reg[PB-2:0], quo_bit};
            end
            if (cmd.issue)
                phase_reg <= phase_reg + quo_reg;
        end
    end

    // Stage 1: table index from the phase fraction.
    assign p_full = FW'(phase_reg[FW-1:0]) * DepthC;
    assign p_idx  = p_full[FW+AW-1:FW];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_reg  <= phase_reg[PB-1:PB-2];
            p1_reg  <= p_idx;
            pc1_reg <= DepthC - {1'b0, p_idx};
            l1_reg  <= cmd.last;
        end
    end

    // Stage 2: two table reads, the end of the quarter reads as one.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sp2_reg <= SineRom[p1_reg];
            sc2_reg <= (pc1_reg == DepthC) ? TrigOne : SineRom[pc1_reg[AW-1:0]];
            q2_reg  <= q1_reg;
            l2_reg  <= l1_reg;
        end
    end

    // Stage 3: quadrant fold and radius products.
    assign sp_s = SW'(sp2_reg);
    assign sc_s = SW'(sc2_reg);

    always_comb
    begin
        case (q2_reg)
            QUAD_FIRST:
            begin
                sin_s = sp_s;
                cos_s = sc_s;
            end
            QUAD_SECOND:
            begin
                sin_s = sc_s;
                cos_s = -sp_s;
            end
            QUAD_THIRD:
            begin
                sin_s = -sp_s;
                cos_s = -sc_s;
            end
            default:
            begin
                sin_s = -sc_s;
                cos_s = sp_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px3_reg <= PW'($signed({1'b0, rx_reg}) * cos_s);
            py3_reg <= PW'($signed({1'b0, ry_reg}) * sin_s);
            l3_reg  <= l2_reg;
        end
    end

    // Stage 4: add centre and half, then truncate toward zero.
    always_comb
    begin
        sum_x = (VW'(cx_reg) <<< 16) + VW'(px3_reg) + VW'(32768);
        sum_y = (VW'(cy_reg) <<< 16) + VW'(py3_reg) + VW'(32768);
        if (sum_x < 0)
            sum_x = sum_x + VW'(65535);
        if (sum_y < 0)
            sum_y = sum_y + VW'(65535);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vx_reg <= sum_x[16+VERTEX_W-1:16];
            vy_reg <= sum_y[16+VERTEX_W-1:16];
            lo_reg <= l3_reg;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    assign out_valid   = vo_reg;
    assign vertex_x    = vx_reg;
    assign vertex_y    = vy_reg;
    assign last_vertex = lo_reg;

endmodule

`default_nettype wire
